// File: src/cts_pkg.sv
// shared types and constants for the csv table splitter
package cts_pkg;

   localparam logic [7:0] QUOTE_BYTE = 8'h22;

   localparam logic [7:0] ROW_SEP_RESET   = 8'd10;
   localparam logic [7:0] FIELD_SEP_RESET = 8'd44;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROW_SEP      = 2'd0,
      CSR_FIELD_SEP    = 2'd1,
      CSR_QUOTE_ENABLE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       field_end;
      logic       row_start;
      logic       row_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] row_separator;
      logic [7:0] field_separator;
      logic       quote_enable;
   } cfg_type;

   typedef struct packed {
      logic inside_quotes;
      logic prev_was_quote;
      logic at_row_start;
   } parse_state_type;

endpackage

// File: src/cts_step.sv
// per-byte split decision: result and next parse state
module cts_step import cts_pkg::*; (
   input  cfg_type         cfg,
   input  parse_state_type state,
   input  req_type         item,
   output logic            emit,
   output rsp_type         result,
   output parse_state_type state_next
);

   logic is_row;
   logic is_sep;
   logic is_quote;
   logic close_field;
   logic row_end;

   always_comb begin
      is_row      = (item.in_byte == cfg.row_separator);
      is_sep      = is_row || (item.in_byte == cfg.field_separator);
      is_quote    = cfg.quote_enable && (item.in_byte == QUOTE_BYTE);
      close_field = item.end_of_buffer || (!state.inside_quotes && is_sep);
      row_end     = item.end_of_buffer || is_row;

      emit       = 1'b1;
      result     = '0;
      state_next = state;

      if (close_field) begin
         result.field_end          = 1'b1;
         result.row_start          = state.at_row_start;
         result.row_end            = row_end;
         state_next.inside_quotes  = 1'b0;
         state_next.prev_was_quote = 1'b0;
         state_next.at_row_start   = row_end;
      end else if (is_quote) begin
         // second quote of a pair re-enters quote mode and gives one literal quote
         state_next.inside_quotes  = !state.inside_quotes;
         state_next.prev_was_quote = 1'b1;
         emit                      = !state.inside_quotes && state.prev_was_quote;
         result.out_byte           = QUOTE_BYTE;
      end else begin
         state_next.prev_was_quote = 1'b0;
         result.out_byte           = item.in_byte;
      end
   end

endmodule

// File: src/csv_table_splitter_top.sv
// top level of the csv table splitter
// Splits a byte stream into fields and rows, one byte per cycle unless rsp is stalled.
// Each transfer on req carries one byte or the end-of-buffer mark and gives zero or one
// transfer on rsp: a content byte, or a field-end marker with row_start and row_end
// flags. A byte is registered on entry and its result at the output; a new transfer is
// taken every cycle while rsp is not stalled. Doubled quotes in a quoted field yield one
// quote; the end mark closes the last field and returns the parser to its reset state.
// Configuration must be written only while idle; the block does not enforce this.
module csv_table_splitter_top import cts_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type         cfg_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            in_valid_ff;
   req_type         in_data_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;
   logic            emit;
   rsp_type         result;
   logic            out_free;
   logic            stage_go;
   logic            req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign stage_go   = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   cts_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (in_data_ff),
      .emit       (emit),
      .result     (result),
      .state_next (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_separator   <= ROW_SEP_RESET;
         cfg_ff.field_separator <= FIELD_SEP_RESET;
         cfg_ff.quote_enable    <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_SEP:      cfg_ff.row_separator   <= csr_write_data;
            CSR_FIELD_SEP:    cfg_ff.field_separator <= csr_write_data;
            CSR_QUOTE_ENABLE: cfg_ff.quote_enable    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{inside_quotes: 1'b0, prev_was_quote: 1'b0, at_row_start: 1'b1};
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (stage_go) begin
            in_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= stage_go && emit;
         end
         if (stage_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (out_free) begin
         rsp_data_ff <= result;
      end
   end

endmodule

// File: src/cts_checker.sv
// port-level assertions for the csv table splitter, bound to the top level
module cts_checker import cts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transfer changed");

   // no result is shown in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // row flags only travel with a field end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.field_end |-> !rsp_data.row_start && !rsp_data.row_end)
      else $error("row flag on content byte");

   // field end carries no content byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.field_end |-> rsp_data.out_byte == 8'd0)
      else $error("field end with nonzero byte");

endmodule

bind csv_table_splitter_top cts_checker u_cts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
